// ===== hw/rtl/thcd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tar header checker and deframer: state and result types,
// stream constants and the octal field parser. No dependencies.
package thcd_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int SIZE_W      = 36;
	localparam int CHK_W       = 24;
	localparam int SUM_W       = 17;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);
	localparam logic [POS_W-1:0] SIZE_OFF = POS_W'(124);
	localparam logic [POS_W-1:0] SIZE_END = POS_W'(136);
	localparam logic [POS_W-1:0] CHK_OFF  = POS_W'(148);
	localparam logic [POS_W-1:0] CHK_END  = POS_W'(156);
	localparam logic [POS_W-1:0] TYPE_OFF = POS_W'(156);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	// Register index, taken from paddr[ADDR_W-1]
	localparam logic REG_DELIVER = 1'b0;

	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [1:0] ST_REG    = 2'd0;
	localparam logic [1:0] ST_OTHER  = 2'd1;
	localparam logic [1:0] ST_BADSUM = 2'd2;
	localparam logic [1:0] ST_END    = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_PAD    = 2'd2,
		PH_HALT   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		PM_LEAD   = 2'd0,
		PM_DIGITS = 2'd1,
		PM_DONE   = 2'd2,
		PM_NONE   = 2'd3
	} pmode_t;

	typedef struct packed {
		pmode_t              mode;
		logic [SIZE_W-1:0]   val;
	} oct_t;

	typedef struct packed {
		logic              item_kind;
		logic [1:0]        header_status;
		logic [SIZE_W-1:0] entry_size;
		logic [7:0]        type_flag;
		logic [7:0]        out_byte;
		logic              last_data;
	} res_t;

	// One step of octal field parsing: skip leading spaces, accumulate digits,
	// stop at the first other byte.
	function automatic oct_t octal_step(pmode_t mode, logic [SIZE_W-1:0] val,
			logic [7:0] b);
		oct_t r;
		logic dig;
		r.mode = mode;
		r.val  = val;
		dig    = (b >= CH_ZERO) && (b <= CH_SEVEN);
		unique case (mode)
			PM_LEAD: begin
				if (b != CH_SPACE) begin
					if (dig) begin
						r.val  = {val[SIZE_W-4:0], b[2:0]};
						r.mode = PM_DIGITS;
					end else begin
						r.mode = PM_NONE;
					end
				end
			end
			PM_DIGITS: begin
				if (dig) begin
					r.val = {val[SIZE_W-4:0], b[2:0]};
				end else begin
					r.mode = PM_DONE;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/tar_header_check_deframer.sv =====
`timescale 1ns / 1ps
// Streaming tar header checker and deframer. Depends on thcd_pkg,
// thcd_apb_regs and thcd_core.
//
// Feed the archive one byte per item on the in_ channel. Each 512-byte
// header is summed (checksum bytes count as spaces), its octal checksum and
// size fields are parsed and its type flag is kept; on the last header byte
// one header report comes out (item_kind 0) with status, size and type.
// The entry's data bytes follow: for regular files (type '0' or NUL) with
// deliver_data set they come out as data items (item_kind 1, last_data on
// the final one); otherwise they are consumed silently, as is the padding
// up to the next block boundary. An all-zero header reports end of archive
// and a checksum mismatch reports status 2; after either the block drops
// every byte until reset. Throughput is one byte per clock while out_ready
// is high: a byte goes through an input register, then one pass of the
// parse and counter logic into the output register. The output register
// frees the input side while a result waits; in_ready only drops when both
// registers are full and out_ready is low. deliver_data (APB offset 0,
// bit 0, reset 1) is sampled as each data byte is processed; change it
// only while the block is idle.
module tar_header_check_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        item_kind,
	output logic [1:0]                  header_status,
	output logic [35:0]                 entry_size,
	output logic [7:0]                  type_flag,
	output logic [7:0]                  out_byte,
	output logic                        last_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [thcd_pkg::ADDR_W-1:0] paddr,
	input  logic [thcd_pkg::DATA_W-1:0] pwdata,
	output logic [thcd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import thcd_pkg::*;

	logic        deliver_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free, advance;
	logic        has_res;
	res_t        res, res_q;
	logic        out_valid_q;

	thcd_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.deliver_q (deliver_q)
	);

	// Stage 1 advances whenever the output register is empty or being drained
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the byte while the stage is stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	thcd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.deliver (deliver_q),
		.has_res (has_res),
		.res     (res)
	);

	// Output register: load on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign item_kind     = res_q.item_kind;
	assign header_status = res_q.header_status;
	assign entry_size    = res_q.entry_size;
	assign type_flag     = res_q.type_flag;
	assign out_byte      = res_q.out_byte;
	assign last_data     = res_q.last_data;

endmodule

// ===== hw/rtl/thcd_apb_regs.sv =====
`timescale 1ns / 1ps
// APB configuration register file: holds the deliver_data control bit.
// Depends on thcd_pkg.
module thcd_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [thcd_pkg::ADDR_W-1:0] paddr,
	input  logic [thcd_pkg::DATA_W-1:0] pwdata,
	output logic [thcd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic                        deliver_q
);
	import thcd_pkg::*;

	logic sel_deliver;

	assign sel_deliver = (paddr[ADDR_W-1] == REG_DELIVER);
	assign pready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && sel_deliver) begin
			deliver_q <= pwdata[0];
		end
	end

	assign prdata = sel_deliver ? {{(DATA_W-1){1'b0}}, deliver_q} : '0;

endmodule

// ===== hw/rtl/thcd_core.sv =====
`timescale 1ns / 1ps
// Stream state machine: header checksum and field parsing, data walk and
// padding skip. Depends on thcd_pkg.
module thcd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic             deliver,
	output logic             has_res,
	output thcd_pkg::res_t   res
);
	import thcd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [SUM_W-1:0]    sum_q, sum_d, sum_nx;
	logic                nz_q, nz_d, nz_nx;
	logic [CHK_W-1:0]    chk_q, chk_d, chk_nx;
	pmode_t              chk_mode_q, chk_mode_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	pmode_t              size_mode_q, size_mode_d;
	logic [7:0]          type_q, type_d, type_nx;
	logic [SIZE_W-1:0]   left_q, left_d, left_dec;
	logic [POS_W-1:0]    pad_q, pad_d, pad_dec;

	logic                in_chk, in_size, chk_ok, regular;
	oct_t                chk_oct, size_oct, chk_sel, size_sel;
	logic [1:0]          status;

	// Header byte datapath
	assign in_chk  = (pos_q >= CHK_OFF) && (pos_q < CHK_END);
	assign in_size = (pos_q >= SIZE_OFF) && (pos_q < SIZE_END);
	assign chk_oct  = octal_step(chk_mode_q, {{(SIZE_W-CHK_W){1'b0}}, chk_q}, byte_in);
	assign size_oct = octal_step(size_mode_q, size_q, byte_in);
	assign chk_sel  = in_chk ? chk_oct : '{mode: chk_mode_q,
		val: {{(SIZE_W-CHK_W){1'b0}}, chk_q}};
	assign size_sel = in_size ? size_oct : '{mode: size_mode_q, val: size_q};
	assign chk_nx   = chk_sel.val[CHK_W-1:0];
	assign sum_nx   = sum_q + (in_chk ? SUM_W'(CH_SPACE) : SUM_W'(byte_in));
	assign nz_nx    = nz_q | (byte_in != CH_NUL);
	assign type_nx  = (pos_q == TYPE_OFF) ? byte_in : type_q;

	assign chk_ok = ((chk_sel.mode == PM_DIGITS) || (chk_sel.mode == PM_DONE))
		&& (chk_nx == {{(CHK_W-SUM_W){1'b0}}, sum_nx});
	assign regular = (type_nx == CH_ZERO) || (type_nx == CH_NUL);

	always_comb begin
		priority if (!nz_nx) begin
			status = ST_END;
		end else if (!chk_ok) begin
			status = ST_BADSUM;
		end else if (regular) begin
			status = ST_REG;
		end else begin
			status = ST_OTHER;
		end
	end

	assign left_dec = (left_q != '0) ? left_q - SIZE_W'(1) : left_q;
	assign pad_dec  = (pad_q != '0) ? pad_q - POS_W'(1) : pad_q;

	// Next state
	always_comb begin
		logic clear_hdr;
		clear_hdr   = 1'b0;
		phase_d     = phase_q;
		pos_d       = pos_q;
		sum_d       = sum_q;
		nz_d        = nz_q;
		chk_d       = chk_q;
		chk_mode_d  = chk_mode_q;
		size_d      = size_q;
		size_mode_d = size_mode_q;
		type_d      = type_q;
		left_d      = left_q;
		pad_d       = pad_q;
		if (step) begin
			unique case (phase_q)
				PH_HALT: begin
				end
				PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == '0) begin
						phase_d   = PH_HEADER;
						clear_hdr = 1'b1;
					end
				end
				PH_DATA: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						if (pad_q == '0) begin
							phase_d   = PH_HEADER;
							clear_hdr = 1'b1;
						end else begin
							phase_d = PH_PAD;
						end
					end
				end
				PH_HEADER: begin
					sum_d       = sum_nx;
					nz_d        = nz_nx;
					chk_d       = chk_nx;
					chk_mode_d  = chk_sel.mode;
					size_d      = size_sel.val;
					size_mode_d = size_sel.mode;
					type_d      = type_nx;
					if (pos_q != LAST_POS) begin
						pos_d = pos_q + POS_W'(1);
					end else begin
						pos_d = '0;
						priority if (status == ST_BADSUM || status == ST_END) begin
							phase_d = PH_HALT;
						end else if (size_sel.val == '0) begin
							clear_hdr = 1'b1;
						end else begin
							left_d  = size_sel.val;
							pad_d   = POS_W'(0) - size_sel.val[POS_W-1:0];
							phase_d = PH_DATA;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (clear_hdr) begin
			pos_d       = '0;
			sum_d       = '0;
			nz_d        = 1'b0;
			chk_d       = '0;
			chk_mode_d  = PM_LEAD;
			size_d      = '0;
			size_mode_d = PM_LEAD;
			type_d      = '0;
		end
	end

	// Result
	always_comb begin
		has_res = 1'b0;
		res     = '0;
		if (step) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == LAST_POS) begin
						has_res           = 1'b1;
						res.item_kind     = KIND_HDR;
						res.header_status = status;
						res.entry_size    = size_sel.val;
						res.type_flag     = type_nx;
					end
				end
				PH_DATA: begin
					if (((type_q == CH_ZERO) || (type_q == CH_NUL)) && deliver) begin
						has_res       = 1'b1;
						res.item_kind = KIND_DATA;
						res.out_byte  = byte_in;
						res.last_data = (left_dec == '0);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			sum_q       <= '0;
			nz_q        <= 1'b0;
			chk_q       <= '0;
			chk_mode_q  <= PM_LEAD;
			size_q      <= '0;
			size_mode_q <= PM_LEAD;
			type_q      <= '0;
			left_q      <= '0;
			pad_q       <= '0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			sum_q       <= sum_d;
			nz_q        <= nz_d;
			chk_q       <= chk_d;
			chk_mode_q  <= chk_mode_d;
			size_q      <= size_d;
			size_mode_q <= size_mode_d;
			type_q      <= type_d;
			left_q      <= left_d;
			pad_q       <= pad_d;
		end
	end

endmodule

// ===== hw/rtl/thcd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the tar header checker and deframer, with its bind.
// Depends on thcd_pkg and tar_header_check_deframer.
module thcd_port_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        item_kind,
	input logic [1:0]                  header_status,
	input logic [35:0]                 entry_size,
	input logic [7:0]                  type_flag,
	input logic [7:0]                  out_byte,
	input logic                        last_data,
	input logic                        pready
);
	import thcd_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind)
		&& $stable(header_status) && $stable(entry_size) && $stable(type_flag)
		&& $stable(out_byte) && $stable(last_data))
		else $error("result changed while stalled");

	// After an end or bad-checksum report is taken, nothing more comes out
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && item_kind == KIND_HDR
		&& (header_status == ST_BADSUM || header_status == ST_END) |=> !out_valid)
		else $error("result after halt");

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_DATA |->
		header_status == ST_REG && entry_size == '0 && type_flag == '0)
		else $error("data item carries header fields");

	a_hdr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_HDR |-> out_byte == '0 && !last_data)
		else $error("header report carries data fields");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind tar_header_check_deframer thcd_port_checker u_thcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.item_kind     (item_kind),
	.header_status (header_status),
	.entry_size    (entry_size),
	.type_flag     (type_flag),
	.out_byte      (out_byte),
	.last_data     (last_data),
	.pready        (pready)
);
